// ===== rtl/rebd_pkg.sv =====
// Shared types and constants for the rotary encoder and button decoder.
// No dependencies; rebd_cfg_regs, rebd_encoder, rebd_button and the top level use it.
package rebd_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_US  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN    = 2'd3;

    // Register reset values
    localparam logic [19:0] DEBOUNCE_US_RST = 20'd2000;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd800;
    localparam logic [15:0] DOUBLE_WIN_RST  = 16'd350;

    // Default width of the pending detent count
    localparam int DELTA_WIDTH_DEF = 16;

    // Input commands
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // Button event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } press_ev_t;

    // Live configuration
    typedef struct packed {
        logic [19:0] edge_gap_us;
        logic [15:0] long_ms;
        logic [15:0] window_ms;
        logic        double_en;
    } cfg_t;

    // Per-cycle step strobes from the pipeline control to the decoders
    typedef struct packed {
        logic edge_fire;
        logic poll_fire;
    } step_t;

endpackage

// ===== rtl/rebd_in_if.sv =====
// Input channel: edge events and poll ticks with valid/ready.
// Depends on nothing.
interface rebd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] time_us;
    logic [31:0] time_ms;
    logic        clock_level;
    logic        direction_level;
    logic        button_level;

    modport source (output valid, command, time_us, time_ms, clock_level,
                    direction_level, button_level, input ready);
    modport sink   (input valid, command, time_us, time_ms, clock_level,
                    direction_level, button_level, output ready);
endinterface

// ===== rtl/rebd_out_if.sv =====
// Result channel: drained rotation and button event with valid/ready.
// Depends on nothing.
interface rebd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rotate_delta;
    logic [1:0]         press_event;

    modport source (output valid, rotate_delta, press_event, input ready);
    modport sink   (input valid, rotate_delta, press_event, output ready);
endinterface

// ===== rtl/rebd_cfg_regs.sv =====
// Configuration register file, written through a plain write port.
// Depends on rebd_pkg.
module rebd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [rebd_pkg::CFG_IDX_W-1:0]    idx,
    input  logic [rebd_pkg::CFG_DATA_W-1:0]   wdata,
    output rebd_pkg::cfg_t                    cfg
);

    rebd_pkg::cfg_t cfg_reg;

    // Register writes; each field keeps its own width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_gap_us <= rebd_pkg::DEBOUNCE_US_RST;
            cfg_reg.long_ms     <= rebd_pkg::LONG_PRESS_RST;
            cfg_reg.window_ms   <= rebd_pkg::DOUBLE_WIN_RST;
            cfg_reg.double_en   <= 1'b0;
        end
        else if (we)
        begin
            unique case (idx)
                rebd_pkg::REG_DEBOUNCE_US: cfg_reg.edge_gap_us <= wdata[19:0];
                rebd_pkg::REG_LONG_PRESS:  cfg_reg.long_ms     <= wdata[15:0];
                rebd_pkg::REG_DOUBLE_WIN:  cfg_reg.window_ms   <= wdata[15:0];
                rebd_pkg::REG_DOUBLE_EN:   cfg_reg.double_en   <= wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rebd_encoder.sv =====
// Debounced quadrature edge counter with a saturating pending detent count.
// Depends on rebd_pkg.
module rebd_encoder #(
    parameter int DELTA_WIDTH = rebd_pkg::DELTA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rebd_pkg::step_t        step,
    input  logic [19:0]            edge_gap_us,
    input  logic [31:0]            now_us,
    input  logic                   clk_level,
    input  logic                   dir_level,
    output logic [DELTA_WIDTH-1:0] pending
);

    localparam logic [DELTA_WIDTH-1:0] DMAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
    localparam logic [DELTA_WIDTH-1:0] DMIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};
    localparam logic [DELTA_WIDTH-1:0] ONE  = {{(DELTA_WIDTH-1){1'b0}}, 1'b1};

    logic [DELTA_WIDTH-1:0] pending_reg, pending_next;
    logic                   last_clk_reg, last_clk_next;
    logic [31:0]            last_time_reg, last_time_next;
    logic [31:0]            since;
    logic                   take;

    // Edge qualification: outside the debounce window and a real level change
    assign since = now_us - last_time_reg;
    assign take  = step.edge_fire && (since >= {12'd0, edge_gap_us})
                   && (clk_level != last_clk_reg);

    always_comb
    begin
        pending_next   = pending_reg;
        last_clk_next  = last_clk_reg;
        last_time_next = last_time_reg;
        if (step.poll_fire)
        begin
            pending_next = '0;
        end
        else if (take)
        begin
            last_clk_next  = clk_level;
            last_time_next = now_us;
            // falling edge counts one detent, saturating at the signed limits
            if (!clk_level)
            begin
                if (dir_level && (pending_reg != DMAX))
                    pending_next = pending_reg + ONE;
                else if (!dir_level && (pending_reg != DMIN))
                    pending_next = pending_reg - ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            last_clk_reg  <= 1'b1;
            last_time_reg <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            last_clk_reg  <= last_clk_next;
            last_time_reg <= last_time_next;
        end
    end

    assign pending = pending_reg;

endmodule

// ===== rtl/rebd_button.sv =====
// Button classifier: short, long and double press with optional deferral.
// Depends on rebd_pkg.
module rebd_button (
    input  logic                clk,
    input  logic                rst_n,
    input  rebd_pkg::step_t     step,
    input  rebd_pkg::cfg_t      cfg,
    input  logic [31:0]         now_ms,
    input  logic                sw,
    output rebd_pkg::press_ev_t ev
);

    logic        last_btn_reg, last_btn_next;
    logic [31:0] start_reg, start_next;
    logic        long_reg, long_next;
    logic        def_reg, def_next;
    logic [31:0] def_time_reg, def_time_next;
    logic [31:0] held;
    logic        is_long;

    assign held    = now_ms - start_reg;
    assign is_long = held >= {16'd0, cfg.long_ms};

    // Classification for one poll tick
    always_comb
    begin
        ev            = rebd_pkg::EV_NONE;
        start_next    = start_reg;
        long_next     = long_reg;
        def_next      = def_reg;
        def_time_next = def_time_reg;
        priority if (last_btn_reg && !sw)
        begin
            // press: second click of a deferred short is a double
            if (def_reg && cfg.double_en)
            begin
                def_next  = 1'b0;
                ev        = rebd_pkg::EV_DOUBLE;
                long_next = 1'b1;
            end
            start_next = now_ms;
        end
        else if (!last_btn_reg && sw)
        begin
            // release
            if (!long_reg && !is_long)
            begin
                if (cfg.double_en)
                begin
                    def_next      = 1'b1;
                    def_time_next = now_ms;
                end
                else
                begin
                    ev = rebd_pkg::EV_SHORT;
                end
            end
            long_next = 1'b0;
        end
        else if (!last_btn_reg && !sw)
        begin
            // held down
            if (!long_reg && is_long)
            begin
                long_next = 1'b1;
                def_next  = 1'b0;
                ev        = rebd_pkg::EV_LONG;
            end
        end
        else
        begin
        end
        last_btn_next = sw;

        // deferred short expires once the double window has passed
        if (def_next && ((now_ms - def_time_next) >= {16'd0, cfg.window_ms}))
        begin
            def_next = 1'b0;
            ev       = rebd_pkg::EV_SHORT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_btn_reg <= 1'b1;
            start_reg    <= '0;
            long_reg     <= 1'b0;
            def_reg      <= 1'b0;
            def_time_reg <= '0;
        end
        else if (step.poll_fire)
        begin
            last_btn_reg <= last_btn_next;
            start_reg    <= start_next;
            long_reg     <= long_next;
            def_reg      <= def_next;
            def_time_reg <= def_time_next;
        end
    end

endmodule

// ===== rtl/rotary_encoder_button_decoder.sv =====
// Top level of the rotary encoder and button decoder.
// Depends on rebd_pkg, rebd_in_if, rebd_out_if, rebd_cfg_regs, rebd_encoder,
// rebd_button.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  in_ch    | in  | valid/ready        | command, time_us, time_ms, clock_level,
//           |     |                    | direction_level, button_level
//  out_ch   | out | valid/ready        | rotate_delta, press_event
//  cfg      | in  | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls: an item passes the input register,
// and a poll tick's result is then written to the output register. Edge events
// produce no result.
// The decoder state update of each item is a single compare-and-update pass.
// A stalled output holds a poll tick in the input register, and with it the
// input; edge events pass freely while no tick is waiting there.
// Reset clears valids and restores register and decoder reset values.
module rotary_encoder_button_decoder #(
    parameter int DELTA_WIDTH = rebd_pkg::DELTA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rebd_in_if.sink                         in_ch,
    rebd_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [rebd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rebd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    typedef struct packed {
        logic        command;
        logic [31:0] time_us;
        logic [31:0] time_ms;
        logic        clock_level;
        logic        direction_level;
        logic        button_level;
    } item_t;

    rebd_pkg::cfg_t         cfg;
    rebd_pkg::step_t        step;
    rebd_pkg::press_ev_t    ev;
    logic [DELTA_WIDTH-1:0] pending;
    logic signed [31:0]     delta_ext;

    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic               s1_poll, s1_move, out_free;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_delta_reg;
    logic [1:0]         out_event_reg;

    rebd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .idx   (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    // Pipeline control: an item leaves the input register when it can finish
    assign s1_poll  = (s1_item_reg.command == rebd_pkg::CMD_POLL);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_move  = s1_valid_reg && (!s1_poll || out_free);
    assign in_ch.ready = !s1_valid_reg || s1_move;

    assign step.edge_fire = s1_move && !s1_poll;
    assign step.poll_fire = s1_move && s1_poll;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_item_reg.command         <= in_ch.command;
            s1_item_reg.time_us         <= in_ch.time_us;
            s1_item_reg.time_ms         <= in_ch.time_ms;
            s1_item_reg.clock_level     <= in_ch.clock_level;
            s1_item_reg.direction_level <= in_ch.direction_level;
            s1_item_reg.button_level    <= in_ch.button_level;
        end
    end

    rebd_encoder #(
        .DELTA_WIDTH (DELTA_WIDTH)
    ) u_enc (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .edge_gap_us (cfg.edge_gap_us),
        .now_us      (s1_item_reg.time_us),
        .clk_level   (s1_item_reg.clock_level),
        .dir_level   (s1_item_reg.direction_level),
        .pending     (pending)
    );

    rebd_button u_btn (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .now_ms (s1_item_reg.time_ms),
        .sw     (s1_item_reg.button_level),
        .ev     (ev)
    );

    // Result register; the drained count is sign extended, then cut to 16 bits
    assign delta_ext = 32'(signed'(pending));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step.poll_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step.poll_fire)
        begin
            out_delta_reg <= delta_ext[15:0];
            out_event_reg <= ev;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.rotate_delta = out_delta_reg;
    assign out_ch.press_event  = out_event_reg;

endmodule
